[rtl/core/free_look_camera_step_top_assert.svh]
`ifndef FREE_LOOK_CAMERA_STEP_TOP_ASSERT_SVH
`define FREE_LOOK_CAMERA_STEP_TOP_ASSERT_SVH

// consequent in the cycle after the antecedent
`define FCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

// consequent in the same cycle
`define FCS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/core/fcs_pkg.sv]
package fcs_pkg;

	localparam logic [1:0] REG_MOVE_SPEED = 2'd0;
	localparam logic [1:0] REG_PITCH_MIN  = 2'd1;
	localparam logic [1:0] REG_PITCH_MAX  = 2'd2;
	localparam logic [1:0] REG_UNUSED     = 2'd3;

	localparam int QUARTER     = 9000;
	localparam int FULL_CIRCLE = 36000;
	localparam logic signed [18:0] RECIP_100 = 19'sd167773;

	typedef struct packed {
		logic [13:0] r;
		logic        neg;
	} fcs_quad_t;

	function automatic logic [15:0] sin_tab(input logic [6:0] d);
		logic [15:0] v;
		case (d)
			7'd0: v = 16'd0;      7'd1: v = 16'd572;    7'd2: v = 16'd1144;
			7'd3: v = 16'd1715;   7'd4: v = 16'd2286;   7'd5: v = 16'd2856;
			7'd6: v = 16'd3425;   7'd7: v = 16'd3993;   7'd8: v = 16'd4560;
			7'd9: v = 16'd5126;   7'd10: v = 16'd5690;  7'd11: v = 16'd6252;
			7'd12: v = 16'd6813;  7'd13: v = 16'd7371;  7'd14: v = 16'd7927;
			7'd15: v = 16'd8481;  7'd16: v = 16'd9032;  7'd17: v = 16'd9580;
			7'd18: v = 16'd10126; 7'd19: v = 16'd10668; 7'd20: v = 16'd11207;
			7'd21: v = 16'd11743; 7'd22: v = 16'd12275; 7'd23: v = 16'd12803;
			7'd24: v = 16'd13328; 7'd25: v = 16'd13848; 7'd26: v = 16'd14365;
			7'd27: v = 16'd14876; 7'd28: v = 16'd15384; 7'd29: v = 16'd15886;
			7'd30: v = 16'd16384; 7'd31: v = 16'd16877; 7'd32: v = 16'd17364;
			7'd33: v = 16'd17847; 7'd34: v = 16'd18324; 7'd35: v = 16'd18795;
			7'd36: v = 16'd19261; 7'd37: v = 16'd19720; 7'd38: v = 16'd20174;
			7'd39: v = 16'd20622; 7'd40: v = 16'd21063; 7'd41: v = 16'd21498;
			7'd42: v = 16'd21926; 7'd43: v = 16'd22348; 7'd44: v = 16'd22763;
			7'd45: v = 16'd23170; 7'd46: v = 16'd23571; 7'd47: v = 16'd23965;
			7'd48: v = 16'd24351; 7'd49: v = 16'd24730; 7'd50: v = 16'd25102;
			7'd51: v = 16'd25466; 7'd52: v = 16'd25822; 7'd53: v = 16'd26170;
			7'd54: v = 16'd26510; 7'd55: v = 16'd26842; 7'd56: v = 16'd27166;
			7'd57: v = 16'd27482; 7'd58: v = 16'd27789; 7'd59: v = 16'd28088;
			7'd60: v = 16'd28378; 7'd61: v = 16'd28660; 7'd62: v = 16'd28932;
			7'd63: v = 16'd29197; 7'd64: v = 16'd29452; 7'd65: v = 16'd29698;
			7'd66: v = 16'd29935; 7'd67: v = 16'd30163; 7'd68: v = 16'd30382;
			7'd69: v = 16'd30592; 7'd70: v = 16'd30792; 7'd71: v = 16'd30983;
			7'd72: v = 16'd31164; 7'd73: v = 16'd31336; 7'd74: v = 16'd31499;
			7'd75: v = 16'd31651; 7'd76: v = 16'd31795; 7'd77: v = 16'd31928;
			7'd78: v = 16'd32052; 7'd79: v = 16'd32166; 7'd80: v = 16'd32270;
			7'd81: v = 16'd32365; 7'd82: v = 16'd32449; 7'd83: v = 16'd32524;
			7'd84: v = 16'd32588; 7'd85: v = 16'd32643; 7'd86: v = 16'd32688;
			7'd87: v = 16'd32723; 7'd88: v = 16'd32748; 7'd89: v = 16'd32763;
			default: v = 16'd32768;
		endcase
		return v;
	endfunction

endpackage

[rtl/core/fcs_mul.sv]
module fcs_mul (
	input  logic               clk,
	input  logic signed [24:0] mul_a,
	input  logic signed [18:0] mul_b,
	output logic signed [43:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

endmodule

[rtl/core/fcs_angle.sv]
module fcs_angle (
	input  logic signed [16:0] ang,
	output fcs_pkg::fcs_quad_t quad
);

	logic signed [17:0] a_ext;
	logic signed [17:0] a_w;
	logic [15:0]        a_n;
	logic [1:0]         q;
	logic [13:0]        r_raw;

	always_comb begin
		a_ext = {ang[16], ang};
		if (a_ext < 0) begin
			a_w = a_ext + 18'(fcs_pkg::FULL_CIRCLE);
		end else if (a_ext >= 18'(fcs_pkg::FULL_CIRCLE)) begin
			a_w = a_ext - 18'(fcs_pkg::FULL_CIRCLE);
		end else begin
			a_w = a_ext;
		end
		a_n = a_w[15:0];
		if (a_n >= 16'(3 * fcs_pkg::QUARTER)) begin
			q = 2'd3;
			r_raw = 14'(a_n - 16'(3 * fcs_pkg::QUARTER));
		end else if (a_n >= 16'(2 * fcs_pkg::QUARTER)) begin
			q = 2'd2;
			r_raw = 14'(a_n - 16'(2 * fcs_pkg::QUARTER));
		end else if (a_n >= 16'(fcs_pkg::QUARTER)) begin
			q = 2'd1;
			r_raw = 14'(a_n - 16'(fcs_pkg::QUARTER));
		end else begin
			q = 2'd0;
			r_raw = a_n[13:0];
		end
		quad.r   = q[0] ? 14'(fcs_pkg::QUARTER) - r_raw : r_raw;
		quad.neg = q[1];
	end

endmodule

[rtl/core/free_look_camera_step_top.sv]
// Requests do not overlap: in_stall stays high until the current request leaves S_OUT.
// Four sine evaluations, two front products, the speed by frame-time product and
// six movement partial products run through one shared multiplier.
// A finished result waits in the output register while the next request runs.
// Reset (arst_n low, asynchronous): yaw and pitch 0, move_speed 256,
// pitch limits -8900 / 8900, no result pending.
module free_look_camera_step_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [5:0]         move_keys,
	input  logic [15:0]        frame_time,
	input  logic signed [9:0]  mouse_dx,
	input  logic signed [9:0]  mouse_dy,
	input  logic signed [31:0] pos_in_x,
	input  logic signed [31:0] pos_in_y,
	input  logic signed [31:0] pos_in_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_out_x,
	output logic signed [31:0] pos_out_y,
	output logic signed [31:0] pos_out_z,
	output logic signed [15:0] front_x,
	output logic signed [15:0] front_y,
	output logic signed [15:0] front_z
);

	typedef enum logic [3:0] {
		S_IDLE, S_TA, S_TD, S_TM, S_TQ, S_TR, S_FX, S_FZ, S_FY, S_V,
		S_C, S_ML, S_MH, S_ACC, S_RND, S_OUT
	} state_t;

	function automatic logic signed [15:0] sat16(input logic signed [17:0] x);
		if (x > 18'sd32767) return 16'sh7fff;
		if (x < -18'sd32768) return 16'sh8000;
		return x[15:0];
	endfunction

	function automatic logic signed [15:0] rnd15(input logic signed [43:0] p);
		logic signed [43:0] t;
		t = (p + 44'sd16384) >>> 15;
		return sat16(t[17:0]);
	endfunction

	// {minus only, plus only} -> 2'b10 / 2'b01, else cancel
	function automatic logic [1:0] move_keys_f(input logic minus, input logic plus);
		return {minus & ~plus, plus & ~minus};
	endfunction

	state_t state_q;
	logic [1:0] ang_idx_q;
	logic [1:0] axis_q;
	logic       out_valid_q;

	logic [23:0]        speed_q;
	logic signed [14:0] pmin_q;
	logic [13:0]        pmax_q;
	logic [15:0]        yaw_q;
	logic signed [14:0] pitch_q;

	logic [5:0]         keys_q;
	logic [15:0]        dt_q;
	logic signed [31:0] pos_q [3];
	logic signed [31:0] res_q [3];
	logic signed [15:0] fr_q [3];
	logic signed [16:0] sin_q [4];
	logic [13:0]        r_q;
	logic               neg_q;
	logic [6:0]         d_q;
	logic [6:0]         f_q;
	logic [15:0]        base_q;
	logic [39:0]        v_q;
	logic signed [18:0] c_q;
	logic signed [59:0] acc_q;

	logic signed [31:0] pos_out_x_q, pos_out_y_q, pos_out_z_q;
	logic signed [15:0] front_x_q, front_y_q, front_z_q;

	logic signed [16:0] ang;
	fcs_pkg::fcs_quad_t quad;
	logic signed [24:0] mul_a;
	logic signed [18:0] mul_b;
	logic signed [43:0] prod_q;

	logic signed [16:0] dx10, dy10, ysum, psum, pmin_ext, pmax_ext;
	logic [6:0]         d_new;
	logic [15:0]        tab_lo, tab_hi;
	logic [9:0]         diff;
	logic [16:0]        s_mag;
	logic signed [16:0] s_val;
	logic signed [15:0] rt_sel;
	logic signed [18:0] c_new;
	logic [1:0]         pm_f, pm_r, pm_u;
	logic signed [59:0] rnd_t;
	logic signed [31:0] sat_res;

	fcs_angle u_angle (.ang(ang), .quad(quad));
	fcs_mul u_mul (.clk(clk), .mul_a(mul_a), .mul_b(mul_b), .prod_q(prod_q));

	always_comb begin
		case (ang_idx_q)
			2'd0: ang = {1'b0, yaw_q};
			2'd1: ang = {1'b0, yaw_q} + 17'(fcs_pkg::QUARTER);
			2'd2: ang = 17'(pitch_q);
			default: ang = 17'(pitch_q) + 17'(fcs_pkg::QUARTER);
		endcase

		dx10 = 17'(mouse_dx) * 17'sd10;
		dy10 = 17'(mouse_dy) * 17'sd10;
		ysum = {1'b0, yaw_q} + dx10;
		psum = 17'(pitch_q) + dy10;
		pmin_ext = 17'(pmin_q);
		pmax_ext = {3'b0, pmax_q};

		d_new  = prod_q[30:24];
		tab_lo = fcs_pkg::sin_tab(d_q);
		tab_hi = fcs_pkg::sin_tab(d_q + 7'd1);
		diff   = 10'(tab_hi - tab_lo);
		s_mag  = {1'b0, base_q} + {7'b0, prod_q[33:24]};
		s_val  = neg_q ? -$signed(s_mag) : $signed(s_mag);

		// movement direction per axis
		pm_f = {move_keys_f(keys_q[1], keys_q[0])};
		pm_r = {move_keys_f(keys_q[3], keys_q[2])};
		pm_u = {move_keys_f(keys_q[5], keys_q[4])};
		case (axis_q)
			2'd0: rt_sel = sat16(-18'(sin_q[0]));
			2'd2: rt_sel = sat16(18'(sin_q[1]));
			default: rt_sel = 16'sd0;
		endcase
		c_new = 19'sd0;
		if (pm_f == 2'b01) c_new = c_new + 19'(fr_q[axis_q]);
		if (pm_f == 2'b10) c_new = c_new - 19'(fr_q[axis_q]);
		if (pm_r == 2'b01) c_new = c_new + 19'(rt_sel);
		if (pm_r == 2'b10) c_new = c_new - 19'(rt_sel);
		if (axis_q == 2'd1 && pm_u == 2'b01) c_new = c_new + 19'sd32768;
		if (axis_q == 2'd1 && pm_u == 2'b10) c_new = c_new - 19'sd32768;

		rnd_t = (acc_q + 60'sd4194304) >>> 23;
		if (rnd_t > 60'sd2147483647) sat_res = 32'sh7fffffff;
		else if (rnd_t < -60'sd2147483648) sat_res = 32'sh80000000;
		else sat_res = rnd_t[31:0];

		mul_a = 25'sd0;
		mul_b = 19'sd0;
		case (state_q)
			S_TA: begin
				mul_a = {11'b0, quad.r};
				mul_b = fcs_pkg::RECIP_100;
			end
			S_TM: begin
				mul_a = {15'b0, diff};
				mul_b = {12'b0, f_q};
			end
			S_TQ: begin
				mul_a = {8'b0, prod_q[16:0]} + 25'sd50;
				mul_b = fcs_pkg::RECIP_100;
			end
			S_FX: begin
				mul_a = 25'(sin_q[1]);
				mul_b = 19'(sin_q[3]);
			end
			S_FZ: begin
				mul_a = 25'(sin_q[0]);
				mul_b = 19'(sin_q[3]);
			end
			S_FY: begin
				mul_a = {1'b0, speed_q};
				mul_b = {3'b0, dt_q};
			end
			S_ML: begin
				mul_a = {5'b0, v_q[19:0]};
				mul_b = c_q;
			end
			S_MH: begin
				mul_a = {5'b0, v_q[39:20]};
				mul_b = c_q;
			end
			default: begin
				mul_a = 25'sd0;
				mul_b = 19'sd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ang_idx_q   <= 2'd0;
			axis_q      <= 2'd0;
			out_valid_q <= 1'b0;
			speed_q     <= 24'd256;
			pmin_q      <= -15'sd8900;
			pmax_q      <= 14'd8900;
			yaw_q       <= 16'd0;
			pitch_q     <= 15'sd0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					fcs_pkg::REG_MOVE_SPEED: speed_q <= cfg_data;
					fcs_pkg::REG_PITCH_MIN:  pmin_q <= cfg_data[14:0];
					fcs_pkg::REG_PITCH_MAX:  pmax_q <= cfg_data[13:0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall && state_q != S_OUT) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						keys_q <= move_keys;
						dt_q   <= frame_time;
						pos_q[0] <= pos_in_x;
						pos_q[1] <= pos_in_y;
						pos_q[2] <= pos_in_z;
						if (ysum >= 17'(fcs_pkg::FULL_CIRCLE)) begin
							yaw_q <= 16'(ysum - 17'(fcs_pkg::FULL_CIRCLE));
						end else if (ysum < 0) begin
							yaw_q <= 16'(ysum + 17'(fcs_pkg::FULL_CIRCLE));
						end else begin
							yaw_q <= ysum[15:0];
						end
						if (psum > pmax_ext) pitch_q <= pmax_ext[14:0];
						else if (psum < pmin_ext) pitch_q <= pmin_ext[14:0];
						else pitch_q <= psum[14:0];
						ang_idx_q <= 2'd0;
						state_q <= S_TA;
					end
				end
				S_TA: begin
					r_q   <= quad.r;
					neg_q <= quad.neg;
					state_q <= S_TD;
				end
				S_TD: begin
					d_q <= d_new;
					f_q <= 7'(r_q - 14'({7'b0, d_new} * 14'd100));
					state_q <= S_TM;
				end
				S_TM: begin
					base_q <= tab_lo;
					state_q <= S_TQ;
				end
				S_TQ: state_q <= S_TR;
				S_TR: begin
					sin_q[ang_idx_q] <= s_val;
					if (ang_idx_q == 2'd3) begin
						state_q <= S_FX;
					end else begin
						ang_idx_q <= ang_idx_q + 2'd1;
						state_q <= S_TA;
					end
				end
				S_FX: state_q <= S_FZ;
				S_FZ: begin
					fr_q[0] <= rnd15(prod_q);
					state_q <= S_FY;
				end
				S_FY: begin
					fr_q[2] <= rnd15(prod_q);
					fr_q[1] <= sat16(18'(sin_q[2]));
					state_q <= S_V;
				end
				S_V: begin
					v_q <= prod_q[39:0];
					axis_q <= 2'd0;
					state_q <= S_C;
				end
				S_C: begin
					c_q <= c_new;
					state_q <= S_ML;
				end
				S_ML: state_q <= S_MH;
				S_MH: begin
					acc_q <= {{5{pos_q[axis_q][31]}}, pos_q[axis_q], 23'b0} + 60'(prod_q);
					state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q <= acc_q + {prod_q[39:0], 20'b0};
					state_q <= S_RND;
				end
				S_RND: begin
					res_q[axis_q] <= sat_res;
					if (axis_q == 2'd2) begin
						state_q <= S_OUT;
					end else begin
						axis_q <= axis_q + 2'd1;
						state_q <= S_C;
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						pos_out_x_q <= res_q[0];
						pos_out_y_q <= res_q[1];
						pos_out_z_q <= res_q[2];
						front_x_q   <= fr_q[0];
						front_y_q   <= fr_q[1];
						front_z_q   <= fr_q[2];
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign pos_out_x = pos_out_x_q;
	assign pos_out_y = pos_out_y_q;
	assign pos_out_z = pos_out_z_q;
	assign front_x   = front_x_q;
	assign front_y   = front_y_q;
	assign front_z   = front_z_q;

endmodule

[rtl/core/fcs_checker.sv]
`include "free_look_camera_step_top_assert.svh"

module fcs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_we,
	input logic [1:0]         cfg_index,
	input logic [23:0]        cfg_data,
	input logic               in_valid,
	input logic               in_stall,
	input logic [5:0]         move_keys,
	input logic [15:0]        frame_time,
	input logic signed [9:0]  mouse_dx,
	input logic signed [9:0]  mouse_dy,
	input logic signed [31:0] pos_in_x,
	input logic signed [31:0] pos_in_y,
	input logic signed [31:0] pos_in_z,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] pos_out_x,
	input logic signed [31:0] pos_out_y,
	input logic signed [31:0] pos_out_z,
	input logic signed [15:0] front_x,
	input logic signed [15:0] front_y,
	input logic signed [15:0] front_z
);

	`FCS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
	`FCS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(pos_out_x) && $stable(front_z), "stalled result changed")
	`FCS_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall, "not busy after request")
	`FCS_ASSERT_NOW(a_res_from_busy, $rose(out_valid), $past(in_stall), "result without request in work")

endmodule

bind free_look_camera_step_top fcs_checker u_fcs_checker (.*);
